// ----- hdl/arp_icmp_header_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// ARP / ICMP header classifier assertion macros
// Shorthand for clocked implication checks with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ARP_ICMP_HEADER_CLASSIFIER_ASSERT_SVH
`define ARP_ICMP_HEADER_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define AIC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aic check failed: same-cycle implication");

// next-cycle implication
`define AIC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aic check failed: next-cycle implication");

`endif

// ----- hdl/aic_pkg.sv -----
// ----------------------------------------------------------------------------
// aic_pkg
// Types and protocol constants shared by the ARP / ICMP header classifier
// ----------------------------------------------------------------------------
`default_nettype none

package aic_pkg;

    // number of header words kept per frame
    localparam int unsigned HDR_WORDS = 11;
    localparam int unsigned POS_W     = 4;

    // frame classes
    localparam logic [1:0] CLASS_NONE      = 2'd0;
    localparam logic [1:0] CLASS_ARP_REQ   = 2'd1;
    localparam logic [1:0] CLASS_ECHO_REQ  = 2'd2;
    localparam logic [1:0] CLASS_ARP_REPLY = 2'd3;

    // input word kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ARM   = 1'b1;

    // header match constants, wire bytes packed little-endian
    localparam logic [31:0] ARP_TYPE_WORD  = 32'h0100_0608;
    localparam logic [31:0] ARP_FMT_WORD   = 32'h0406_0008;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0100;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0200;
    localparam logic [31:0] IPV4_TYPE_WORD = 32'h0045_0008;
    localparam logic [7:0]  IP_PROTO_ICMP  = 8'h01;
    localparam logic [15:0] ICMP_ECHO_REQ  = 16'h0008;
    localparam logic [15:0] ECHO_OVERHEAD  = 16'd28;

    typedef logic [HDR_WORDS-1:0][31:0] header_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] frame_word;
        logic        last_word;
    } item_t;

    typedef struct packed {
        logic [1:0]  frame_class;
        logic [31:0] peer_mac_low;
        logic [15:0] peer_mac_high;
        logic [31:0] peer_ip;
        logic [15:0] echo_ident;
        logic [15:0] echo_sequence;
        logic [15:0] echo_length;
    } result_t;

    // pending classification between capture and classify
    typedef struct packed {
        logic valid;
        logic full;
    } pend_t;

endpackage

`default_nettype wire

// ----- hdl/arp_icmp_header_classifier.sv -----
// Throughput: one word per cycle unless a frame end waits on a stalled result.
// The header store and a pending flag feed one classify stage into a result
// register, which holds while stalled; the pending flag holds each frame end.
// Reset (rst_n, async, active low) clears position, pending and valid flags,
// the armed flag and both address registers; header words are not cleared.
// ----------------------------------------------------------------------------
// arp_icmp_header_classifier
// Classifies ARP and ICMP echo frames from their first eleven header words
// ----------------------------------------------------------------------------
`default_nettype none

module arp_icmp_header_classifier (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire aic_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output aic_pkg::result_t      result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [31:0]      cfg_data
);
    import aic_pkg::*;

    localparam logic REG_OWN_IP     = 1'b0;
    localparam logic REG_AWAITED_IP = 1'b1;

    logic [31:0] own_ip_reg;
    logic [31:0] awaited_ip_reg;
    logic        armed_reg;
    logic        armed_next;
    logic        valid_reg;
    logic        valid_next;
    result_t     result_reg;

    header_t     header;
    pend_t       status;
    result_t     class_result;
    logic        reply_hit;
    logic        accept;
    logic        out_free;
    logic        take;

    // handshake
    assign out_free   = !valid_reg || result_ready;
    assign take       = status.valid && out_free;
    assign item_ready = !status.valid || out_free;
    assign accept     = item_valid && item_ready;

    aic_capture u_capture (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .take   (take),
        .header (header),
        .status (status)
    );

    aic_classify u_classify (
        .header     (header),
        .full       (status.full),
        .own_ip     (own_ip_reg),
        .awaited_ip (awaited_ip_reg),
        .armed      (armed_reg),
        .result     (class_result),
        .reply_hit  (reply_hit)
    );

    // arm command wins over a reply taken in the same cycle
    always_comb
    begin
        armed_next = armed_reg;
        if (accept && (item.kind == KIND_ARM))
            armed_next = 1'b1;
        else if (take && reply_hit)
            armed_next = 1'b0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg     <= '0;
            awaited_ip_reg <= '0;
            armed_reg      <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OWN_IP:     own_ip_reg     <= cfg_data;
                    REG_AWAITED_IP: awaited_ip_reg <= cfg_data;
                    default:        own_ip_reg     <= own_ip_reg;
                endcase
            end
            armed_reg <= armed_next;
            valid_reg <= valid_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= class_result;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- hdl/aic_capture.sv -----
// ----------------------------------------------------------------------------
// aic_capture
// Keeps the first header words of a frame and flags a frame end for classify
// ----------------------------------------------------------------------------
`default_nettype none

module aic_capture (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire aic_pkg::item_t  item,
    input  wire logic            take,
    output aic_pkg::header_t     header,
    output aic_pkg::pend_t       status
);
    import aic_pkg::*;

    header_t          hdr_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    pend_t            pend_reg;
    pend_t            pend_next;
    logic             frame_acc;
    logic             frame_end;
    logic             pos_open;

    assign frame_acc = accept && (item.kind == KIND_FRAME);
    assign frame_end = frame_acc && item.last_word;
    assign pos_open  = (pos_reg < POS_W'(HDR_WORDS));

    // word position, saturating once the header is full
    always_comb
    begin
        pos_next = pos_reg;
        if (frame_acc)
        begin
            if (item.last_word)
                pos_next = '0;
            else if (pos_open)
                pos_next = pos_reg + POS_W'(1);
        end
    end

    // pending frame end, held until the result register takes it
    always_comb
    begin
        pend_next = pend_reg;
        if (frame_end)
        begin
            pend_next.valid = 1'b1;
            pend_next.full  = (pos_reg >= POS_W'(HDR_WORDS - 1));
        end
        else if (take)
        begin
            pend_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    // header store, written only at the current position
    always_ff @(posedge clk)
    begin
        if (frame_acc && pos_open)
            hdr_reg[pos_reg] <= item.frame_word;
    end

    assign header = hdr_reg;
    assign status = pend_reg;

endmodule

`default_nettype wire

// ----- hdl/aic_classify.sv -----
// ----------------------------------------------------------------------------
// aic_classify
// Decodes the stored header into a frame class and the peer fields
// ----------------------------------------------------------------------------
`default_nettype none

module aic_classify (
    input  wire aic_pkg::header_t header,
    input  wire logic             full,
    input  wire logic [31:0]      own_ip,
    input  wire logic [31:0]      awaited_ip,
    input  wire logic             armed,
    output aic_pkg::result_t      result,
    output logic                  reply_hit
);
    import aic_pkg::*;

    logic        is_arp;
    logic        arp_req_hit;
    logic        echo_hit;
    logic        arp_rep_hit;
    logic [15:0] ip_total;

    // header field compares
    assign is_arp = (header[3] == ARP_TYPE_WORD) && (header[4] == ARP_FMT_WORD);

    assign arp_req_hit = full && is_arp && (header[5][15:0] == ARP_OP_REQUEST)
                         && (header[9][31:16] == own_ip[15:0])
                         && (header[10][15:0] == own_ip[31:16]);

    assign echo_hit = full && (header[3] == IPV4_TYPE_WORD)
                      && (header[5][31:24] == IP_PROTO_ICMP)
                      && (header[8][31:16] == ICMP_ECHO_REQ)
                      && (header[7][31:16] == own_ip[15:0])
                      && (header[8][15:0] == own_ip[31:16]);

    assign arp_rep_hit = full && armed && is_arp
                         && (header[5][15:0] == ARP_OP_REPLY)
                         && (header[7] == awaited_ip);

    // ip total length is big-endian on the wire
    assign ip_total = {header[4][7:0], header[4][15:8]};

    // priority: arp request, echo request, awaited arp reply
    always_comb
    begin
        result    = '0;
        reply_hit = 1'b0;
        if (arp_req_hit)
        begin
            result.frame_class   = CLASS_ARP_REQ;
            result.peer_mac_low  = {header[6][15:0], header[5][31:16]};
            result.peer_mac_high = header[6][31:16];
            result.peer_ip       = header[7];
        end
        else if (echo_hit)
        begin
            result.frame_class   = CLASS_ECHO_REQ;
            result.peer_mac_low  = {header[2][15:0], header[1][31:16]};
            result.peer_mac_high = header[2][31:16];
            result.peer_ip       = {header[7][15:0], header[6][31:16]};
            result.echo_ident    = header[9][31:16];
            result.echo_sequence = header[10][15:0];
            result.echo_length   = ip_total - ECHO_OVERHEAD;
        end
        else if (arp_rep_hit)
        begin
            result.frame_class   = CLASS_ARP_REPLY;
            result.peer_mac_low  = {header[6][15:0], header[5][31:16]};
            result.peer_mac_high = header[6][31:16];
            result.peer_ip       = header[7];
            reply_hit            = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/aic_checker.sv -----
// ----------------------------------------------------------------------------
// aic_checker
// Port-level checks for the ARP / ICMP header classifier, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_icmp_header_classifier_assert.svh"

module aic_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_ready,
    input  wire aic_pkg::item_t   item,
    input  wire logic             result_valid,
    input  wire logic             result_ready,
    input  wire aic_pkg::result_t result
);
    import aic_pkg::*;

    // stalled result word holds
    `AIC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // a fresh result must have an accepted last frame word behind it
    `AIC_ASSERT_SAME(a_result_source, clk, rst_n, $rose(result_valid), $past(item_valid && item_ready && (item.kind == KIND_FRAME) && item.last_word, 2))

    // class none carries no peer
    `AIC_ASSERT_SAME(a_none_zero, clk, rst_n, result_valid && (result.frame_class == CLASS_NONE), (result.peer_mac_low == '0) && (result.peer_mac_high == '0) && (result.peer_ip == '0))

    // echo fields only for echo requests
    `AIC_ASSERT_SAME(a_echo_zero, clk, rst_n, result_valid && (result.frame_class != CLASS_ECHO_REQ), (result.echo_ident == '0) && (result.echo_sequence == '0) && (result.echo_length == '0))

endmodule

bind arp_icmp_header_classifier aic_checker u_aic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
